/* src/qpu_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion pose unit package
// Shared widths, command codes, bundle types and the rounding and saturation
// helpers used by both quaternion product pipelines.
// ----------------------------------------------------------------------------
package qpu_pkg;

    localparam int WORD_W        = 32;
    localparam int OPND_W        = WORD_W + 1;
    localparam int MID_W         = 48;
    localparam int ACC_W         = MID_W + OPND_W + 2;
    localparam int CMD_W         = 2;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [CMD_W-1:0] CMD_ROTATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INV_POSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QPROD    = 2'd2;

    localparam logic [OPND_W-1:0] ZERO_OPND = {OPND_W{1'b0}};

    // Components are ordered w, x, y, z from index 0 up.
    typedef logic [3:0][OPND_W-1:0] t_opnd4;
    typedef logic [3:0][MID_W-1:0]  t_mid4;
    typedef logic [3:0][WORD_W-1:0] t_word4;
    typedef logic [2:0][WORD_W-1:0] t_word3;

    // Command and the quaternion that multiplies from the right in the
    // second product of a rotation.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_opnd4           conj_op;
    } t_side;

    // Round half up and drop the fraction bits.
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] s,
        input int                      frac
    );
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (frac - 1);
        return (s + half) >>> frac;
    endfunction

    function automatic logic [MID_W-1:0] sat_mid(input logic signed [ACC_W-1:0] v);
        logic [MID_W-1:0] r;
        if (v[ACC_W-1:MID_W-1] == {(ACC_W-MID_W+1){v[ACC_W-1]}}) begin
            r = v[MID_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(MID_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(MID_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v[ACC_W-1:WORD_W-1] == {(ACC_W-WORD_W+1){v[ACC_W-1]}}) begin
            r = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Negate a sign-extended word; only the most negative word overflows.
    function automatic logic [WORD_W-1:0] neg_sat_word(input logic signed [OPND_W-1:0] x);
        logic signed [OPND_W-1:0] n;
        logic [WORD_W-1:0]        r;
        n = -x;
        if (n[OPND_W-1] != n[OPND_W-2]) begin
            r = n[OPND_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r = n[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/qpu_prod_vq.sv */
// ----------------------------------------------------------------------------
// First quaternion product
// Three-stage Hamilton product a * b on 33-bit operands: a 4x4 multiplier
// array, the signed four-term sums, then rounding and saturation to the
// 48-bit intermediate (or to 32 bits for the quaternion product command).
// ----------------------------------------------------------------------------
module qpu_prod_vq #(
    parameter int FRAC_BITS = qpu_pkg::DEF_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  qpu_pkg::t_opnd4 i_a,
    input  qpu_pkg::t_opnd4 i_b,
    input  qpu_pkg::t_side  i_side,
    output logic           o_vld,
    input  logic           i_rdy,
    output qpu_pkg::t_mid4  o_p,
    output qpu_pkg::t_side  o_side
);
    import qpu_pkg::*;

    localparam int NSTG   = 3;
    localparam int PROD_W = 2 * OPND_W;
    localparam int SUM_W  = PROD_W + 2;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   en;

    logic [3:0][3:0][PROD_W-1:0] r_prod, n_prod;
    logic [3:0][SUM_W-1:0]       r_sum, n_sum;
    logic [3:0][ACC_W-1:0]       rnd;
    t_mid4                       r_res, n_res;
    t_side                       r_side [NSTG];

    function automatic logic signed [SUM_W-1:0] pe(input logic [PROD_W-1:0] p);
        return SUM_W'($signed(p));
    endfunction

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        en[NSTG] = i_rdy;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_prod[i][j] = $signed(i_a[i]) * $signed(i_b[j]);
            end
        end
    end

    always_comb begin
        n_sum[0] = pe(r_prod[0][0]) - pe(r_prod[1][1]) - pe(r_prod[2][2]) - pe(r_prod[3][3]);
        n_sum[1] = pe(r_prod[0][1]) + pe(r_prod[1][0]) + pe(r_prod[2][3]) - pe(r_prod[3][2]);
        n_sum[2] = pe(r_prod[0][2]) - pe(r_prod[1][3]) + pe(r_prod[2][0]) + pe(r_prod[3][1]);
        n_sum[3] = pe(r_prod[0][3]) + pe(r_prod[1][2]) - pe(r_prod[2][1]) + pe(r_prod[3][0]);
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rnd[c] = round_shift(ACC_W'($signed(r_sum[c])), FRAC_BITS);
            if (r_side[1].cmd == CMD_QPROD) begin
                n_res[c] = MID_W'($signed(sat_word(rnd[c])));
            end else begin
                n_res[c] = sat_mid(rnd[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_prod    <= n_prod;
            r_side[0] <= i_side;
        end
        if (en[1]) begin
            r_sum     <= n_sum;
            r_side[1] <= r_side[0];
        end
        if (en[2]) begin
            r_res     <= n_res;
            r_side[2] <= r_side[1];
        end
    end

    assign o_rdy  = en[0];
    assign o_vld  = r_vld[NSTG-1];
    assign o_p    = r_res;
    assign o_side = r_side[NSTG-1];

`ifndef SYNTH
    // A product for the quaternion product command is already a 32-bit word.
    a_qprod_fits_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && o_side.cmd == CMD_QPROD) |->
            ((&o_p[0][MID_W-1:WORD_W-1]) || !(|o_p[0][MID_W-1:WORD_W-1])) &&
            ((&o_p[1][MID_W-1:WORD_W-1]) || !(|o_p[1][MID_W-1:WORD_W-1])) &&
            ((&o_p[2][MID_W-1:WORD_W-1]) || !(|o_p[2][MID_W-1:WORD_W-1])) &&
            ((&o_p[3][MID_W-1:WORD_W-1]) || !(|o_p[3][MID_W-1:WORD_W-1])))
        else $error("first product exceeds 32 bits for quaternion product");

    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !en[2]) |=> (r_vld[1] && $stable(r_sum)))
        else $error("stalled sum stage lost its contents");
`endif

endmodule

/* src/qpu_prod_rot.sv */
// ----------------------------------------------------------------------------
// Second quaternion product and result assembly
// Four-stage product of the 48-bit intermediate with the 33-bit conjugate
// operand, split into low and high partial products, then summed, rounded,
// saturated to 32 bits and steered into the result fields by command.
// ----------------------------------------------------------------------------
module qpu_prod_rot #(
    parameter int FRAC_BITS = qpu_pkg::DEF_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  qpu_pkg::t_mid4  i_qv,
    input  qpu_pkg::t_side  i_side,
    output logic           o_vld,
    input  logic           i_rdy,
    output qpu_pkg::t_word4 o_res_q,
    output qpu_pkg::t_word3 o_res_p
);
    import qpu_pkg::*;

    localparam int NSTG   = 4;
    localparam int NTERM  = 12;
    localparam int HI_W   = MID_W - WORD_W;
    localparam int LOP_W  = WORD_W + 1 + OPND_W;
    localparam int HIP_W  = HI_W + OPND_W;
    localparam int TERM_W = MID_W + OPND_W;

    // Left and right factor of each cross term; x, y and z take four each.
    localparam int ROT_AI [NTERM] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
    localparam int ROT_BI [NTERM] = '{1, 0, 3, 2, 2, 3, 0, 1, 3, 2, 1, 0};

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   en;

    logic [NTERM-1:0][LOP_W-1:0]  r_lo, n_lo;
    logic [NTERM-1:0][HIP_W-1:0]  r_hi, n_hi;
    logic [NTERM-1:0][TERM_W-1:0] r_term, n_term;
    logic [2:0][ACC_W-1:0]        r_sum, n_sum;
    t_word3                       rot;
    t_word4                       r_q, n_q;
    t_word3                       r_p, n_p;
    t_side                        r_side [NSTG-1];
    t_word4                       r_qv32 [NSTG-1];

    function automatic logic signed [ACC_W-1:0] te(input logic [TERM_W-1:0] t);
        return ACC_W'($signed(t));
    endfunction

    always_comb begin
        en[NSTG] = i_rdy;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // The 48-bit factor is split into an unsigned low word and a signed top.
    always_comb begin
        for (int t = 0; t < NTERM; t++) begin
            n_lo[t] = $signed({1'b0, i_qv[ROT_AI[t]][WORD_W-1:0]})
                      * $signed(i_side.conj_op[ROT_BI[t]]);
            n_hi[t] = $signed(i_qv[ROT_AI[t]][MID_W-1:WORD_W])
                      * $signed(i_side.conj_op[ROT_BI[t]]);
        end
    end

    always_comb begin
        for (int t = 0; t < NTERM; t++) begin
            n_term[t] = (TERM_W'($signed(r_hi[t])) <<< WORD_W) + TERM_W'($signed(r_lo[t]));
        end
    end

    always_comb begin
        n_sum[0] = te(r_term[0]) + te(r_term[1]) + te(r_term[2]) - te(r_term[3]);
        n_sum[1] = te(r_term[4]) - te(r_term[5]) + te(r_term[6]) + te(r_term[7]);
        n_sum[2] = te(r_term[8]) + te(r_term[9]) - te(r_term[10]) + te(r_term[11]);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rot[c] = sat_word(round_shift(r_sum[c], FRAC_BITS));
        end
        n_q = '0;
        n_p = '0;
        case (r_side[2].cmd)
            CMD_ROTATE: begin
                n_p = rot;
            end
            CMD_INV_POSE: begin
                // The conjugate operand holds the original quaternion here.
                n_p    = rot;
                n_q[0] = r_side[2].conj_op[0][WORD_W-1:0];
                for (int c = 1; c < 4; c++) begin
                    n_q[c] = neg_sat_word(r_side[2].conj_op[c]);
                end
            end
            CMD_QPROD: begin
                n_q = r_qv32[2];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_side[0] <= i_side;
            for (int c = 0; c < 4; c++) begin
                r_qv32[0][c] <= i_qv[c][WORD_W-1:0];
            end
        end
        if (en[1]) begin
            r_term    <= n_term;
            r_side[1] <= r_side[0];
            r_qv32[1] <= r_qv32[0];
        end
        if (en[2]) begin
            r_sum     <= n_sum;
            r_side[2] <= r_side[1];
            r_qv32[2] <= r_qv32[1];
        end
        if (en[3]) begin
            r_q <= n_q;
            r_p <= n_p;
        end
    end

    assign o_rdy   = en[0];
    assign o_vld   = r_vld[NSTG-1];
    assign o_res_q = r_q;
    assign o_res_p = r_p;

`ifndef SYNTH
    a_term_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !en[2]) |=> (r_vld[1] && $stable(r_term)))
        else $error("stalled term stage lost its contents");

    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !en[3]) |=> (r_vld[2] && $stable(r_sum) && $stable(r_side[2])))
        else $error("stalled sum stage lost its contents");
`endif

endmodule

/* src/quaternion_pose_unit_top.sv */
// Path: an input passes the input register, then both product pipelines.
// Throughput: one item per cycle while the output is not stalled; every stage holds
// its own multiplier array (16 products in the first quaternion product, 24
// partial products in the second), so nothing is shared between items in flight.
// Reset: synchronous, active low; it clears the stage valid bits only.
// ----------------------------------------------------------------------------
// Quaternion pose unit
// Fixed-point quaternion ALU: vector rotation, pose inversion and Hamilton
// product, built as an eight-stage pipeline with per-stage flow control.
// ----------------------------------------------------------------------------
module quaternion_pose_unit_top #(
    parameter int FRAC_BITS = qpu_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, opnd_x, opnd_y, opnd_z, opnd_w
    input  logic [8*qpu_pkg::WORD_W-1:0]       i_s_tdata,
    // command
    input  logic [qpu_pkg::CMD_W-1:0]          i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // res_qw, res_qx, res_qy, res_qz, res_px, res_py, res_pz
    output logic [7*qpu_pkg::WORD_W-1:0]       o_m_tdata
);
    import qpu_pkg::*;

    logic [7:0][OPND_W-1:0] ext, neg;
    t_opnd4                 n_a, n_b;
    t_side                  n_side;
    logic                   r_vld;
    t_opnd4                 r_a, r_b;
    t_side                  r_side;
    logic                   en_in;

    logic   vq_rdy, vq_vld, rot_rdy;
    t_mid4  vq_p;
    t_side  vq_side;
    t_word4 res_q;
    t_word3 res_p;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            ext[i] = {i_s_tdata[WORD_W*i+WORD_W-1], i_s_tdata[WORD_W*i +: WORD_W]};
            neg[i] = -$signed(ext[i]);
        end
    end

    // Pose inversion rotates the negated position by the conjugate, so the
    // second product then multiplies by the original quaternion.
    always_comb begin
        n_side.cmd = i_s_tuser;
        case (i_s_tuser)
            CMD_ROTATE: begin
                n_a            = {ext[3], ext[2], ext[1], ext[0]};
                n_b            = {ext[6], ext[5], ext[4], ZERO_OPND};
                n_side.conj_op = {neg[3], neg[2], neg[1], ext[0]};
            end
            CMD_INV_POSE: begin
                n_a            = {neg[3], neg[2], neg[1], ext[0]};
                n_b            = {neg[6], neg[5], neg[4], ZERO_OPND};
                n_side.conj_op = {ext[3], ext[2], ext[1], ext[0]};
            end
            default: begin
                n_a            = {ext[3], ext[2], ext[1], ext[0]};
                n_b            = {ext[6], ext[5], ext[4], ext[7]};
                n_side.conj_op = {ext[3], ext[2], ext[1], ext[0]};
            end
        endcase
    end

    assign en_in = !r_vld || vq_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en_in) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_side <= n_side;
        end
    end

    qpu_prod_vq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prod_vq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .o_rdy   (vq_rdy),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_side  (r_side),
        .o_vld   (vq_vld),
        .i_rdy   (rot_rdy),
        .o_p     (vq_p),
        .o_side  (vq_side)
    );

    qpu_prod_rot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prod_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vq_vld),
        .o_rdy   (rot_rdy),
        .i_qv    (vq_p),
        .i_side  (vq_side),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_res_q (res_q),
        .o_res_p (res_p)
    );

    assign o_s_tready = en_in;
    assign o_m_tdata  = {res_p, res_q};

`ifndef SYNTH
    // Bubbles are squeezed out, so the input only stalls on output backpressure.
    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled while the output side was free");
`endif

endmodule
